// File: rtl/jsu_pkg.sv
// Shared types, codes and helper functions of the JSON string unescaper.
package jsu_pkg;

    localparam logic [7:0] BACKSLASH = 8'h5C;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ESCAPE = 2'd1,
        MODE_HEX    = 2'd2
    } mode_t;

    // Up to three output bytes caused by one input byte; data[0] goes out first.
    typedef struct packed {
        logic [1:0]      count;
        logic [2:0][7:0] data;
        logic            bad;
        logic            fin;
    } grp_t;

    // Bit 4 set when the byte is a hex digit, bits 3:0 hold its value.
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        begin
            r = 5'd0;
            if (b >= 8'h30 && b <= 8'h39)
            begin
                r = {1'b1, b[3:0]};
            end
            else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
            begin
                r = {1'b1, b[3:0] + 4'd9};
            end
            return r;
        end
    endfunction

    // Encode a 16-bit code point as one to three UTF-8 bytes.
    function automatic grp_t utf8_group(input logic [15:0] cp, input logic fin);
        grp_t g;
        begin
            g = '0;
            g.fin = fin;
            if (cp <= 16'h007F)
            begin
                g.count   = 2'd1;
                g.data[0] = cp[7:0];
            end
            else if (cp <= 16'h07FF)
            begin
                g.count   = 2'd2;
                g.data[0] = 8'hC0 | {3'b000, cp[10:6]};
                g.data[1] = 8'h80 | {2'b00, cp[5:0]};
            end
            else
            begin
                g.count   = 2'd3;
                g.data[0] = 8'hE0 | {4'b0000, cp[15:12]};
                g.data[1] = 8'h80 | {2'b00, cp[11:6]};
                g.data[2] = 8'h80 | {2'b00, cp[5:0]};
            end
            return g;
        end
    endfunction

endpackage

// File: rtl/jsu_decode.sv
// Escape scanner: holds the scan state and turns one input byte into a result group.
module jsu_decode (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           take,
    input  logic [7:0]     byte_in,
    input  logic           string_last,
    output jsu_pkg::grp_t  grp
);

    jsu_pkg::mode_t mode_reg, mode_next;
    logic [2:0]     cnt_reg, cnt_next;
    logic [15:0]    acc_reg, acc_next;
    logic           stop_reg, stop_next;
    logic           disc_reg, disc_next;
    logic [4:0]     hex;
    logic [7:0]     esc_byte;
    logic           esc_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= jsu_pkg::MODE_NORMAL;
            cnt_reg  <= 3'd0;
            acc_reg  <= 16'd0;
            stop_reg <= 1'b0;
            disc_reg <= 1'b0;
        end
        else if (take)
        begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
            acc_reg  <= acc_next;
            stop_reg <= stop_next;
            disc_reg <= disc_next;
        end
    end

    always_comb
    begin
        esc_ok   = 1'b1;
        esc_byte = 8'h00;
        case (byte_in)
            8'h22:   esc_byte = 8'h22;
            8'h5C:   esc_byte = 8'h5C;
            8'h2F:   esc_byte = 8'h2F;
            8'h62:   esc_byte = 8'h08;
            8'h66:   esc_byte = 8'h0C;
            8'h6E:   esc_byte = 8'h0A;
            8'h72:   esc_byte = 8'h0D;
            8'h74:   esc_byte = 8'h09;
            default: esc_ok = 1'b0;
        endcase
    end

    assign hex = jsu_pkg::hex_digit(byte_in);

    always_comb
    begin
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        stop_next = stop_reg;
        disc_next = disc_reg;
        grp       = '0;
        grp.fin   = string_last;

        if (!disc_reg)
        begin
            case (mode_reg)
                jsu_pkg::MODE_ESCAPE:
                begin
                    mode_next = jsu_pkg::MODE_NORMAL;
                    if (esc_ok)
                    begin
                        grp.count   = 2'd1;
                        grp.data[0] = esc_byte;
                    end
                    else if (byte_in == 8'h75)
                    begin
                        mode_next = jsu_pkg::MODE_HEX;
                        cnt_next  = 3'd0;
                        acc_next  = 16'd0;
                        stop_next = 1'b0;
                        if (string_last)
                        begin
                            grp = jsu_pkg::utf8_group(16'd0, 1'b1);
                        end
                    end
                    else
                    begin
                        // unknown escape: report once, drop the rest of the string
                        grp.count = 2'd1;
                        grp.bad   = 1'b1;
                        disc_next = 1'b1;
                    end
                end
                jsu_pkg::MODE_HEX:
                begin
                    if (!stop_reg && hex[4])
                    begin
                        acc_next = {acc_reg[11:0], hex[3:0]};
                    end
                    else
                    begin
                        stop_next = 1'b1;
                    end
                    cnt_next = cnt_reg + 3'd1;
                    if (cnt_next >= 3'd4 || string_last)
                    begin
                        grp       = jsu_pkg::utf8_group(acc_next, string_last);
                        mode_next = jsu_pkg::MODE_NORMAL;
                        cnt_next  = 3'd0;
                        acc_next  = 16'd0;
                        stop_next = 1'b0;
                    end
                end
                default:
                begin
                    if (byte_in == jsu_pkg::BACKSLASH)
                    begin
                        if (string_last)
                        begin
                            grp.count = 2'd1;
                            grp.bad   = 1'b1;
                        end
                        else
                        begin
                            mode_next = jsu_pkg::MODE_ESCAPE;
                        end
                    end
                    else
                    begin
                        grp.count   = 2'd1;
                        grp.data[0] = byte_in;
                    end
                end
            endcase
        end

        if (string_last)
        begin
            mode_next = jsu_pkg::MODE_NORMAL;
            cnt_next  = 3'd0;
            acc_next  = 16'd0;
            stop_next = 1'b0;
            disc_next = 1'b0;
        end
    end

endmodule

// File: rtl/json_string_unescape_utf8.sv
// Top level of the JSON string unescaper: decoder, two-group result queue, byte serializer.
//
//  channel  | dir | tdata          | tlast       | tuser
//  s_axis   | in  | byte_in[7:0]   | string_last | -
//  m_axis   | out | byte_out[7:0]  | run_last    | [0] bad_escape, [1] string_end
//
// One input byte is taken per cycle while the two-slot group queue has room.
// Each byte yields zero to three output bytes and the output side moves one byte
// per cycle while m_axis_tready is high, so a \u escape that expands to two or three
// bytes can hold s_axis_tready low when more results follow right behind it.
// Each result group is registered in the queue and reaches m_axis behind any groups ahead of it.
// Reset clears the scan state and empties the queue; stalls on m_axis fill the
// queue and then drop s_axis_tready.
module json_string_unescape_utf8 (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] byte_in
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] byte_out
    output logic       m_axis_tlast,
    output logic [1:0] m_axis_tuser    // [0] bad_escape, [1] string_end
);

    jsu_pkg::grp_t grp;
    jsu_pkg::grp_t slot_reg [2];
    jsu_pkg::grp_t head;
    logic          wr_reg, rd_reg;
    logic [1:0]    fill_reg;
    logic [1:0]    idx_reg;
    logic          take, push, pop;

    assign s_axis_tready = (fill_reg != 2'd2);
    assign take          = s_axis_tvalid && s_axis_tready;
    assign push          = take && (grp.count != 2'd0);

    jsu_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .byte_in     (s_axis_tdata),
        .string_last (s_axis_tlast),
        .grp         (grp)
    );

    assign head          = slot_reg[rd_reg];
    assign m_axis_tvalid = (fill_reg != 2'd0);
    assign m_axis_tdata  = head.data[idx_reg];
    assign m_axis_tlast  = (idx_reg == head.count - 2'd1);
    assign m_axis_tuser  = {head.fin, head.bad};
    assign pop           = m_axis_tvalid && m_axis_tready && m_axis_tlast;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= grp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= 1'b0;
            rd_reg   <= 1'b0;
            fill_reg <= 2'd0;
            idx_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (pop)
            begin
                rd_reg  <= ~rd_reg;
                idx_reg <= 2'd0;
            end
            else if (m_axis_tvalid && m_axis_tready)
            begin
                // advance within the group
                idx_reg <= idx_reg + 2'd1;
            end
            case ({push, pop})
                2'b10:   fill_reg <= fill_reg + 2'd1;
                2'b01:   fill_reg <= fill_reg - 2'd1;
                default: fill_reg <= fill_reg;
            endcase
        end
    end

endmodule

// File: rtl/jsu_check.sv
// Port-level checker for the JSON string unescaper, bound to the top level.
module jsu_check (
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast,
    input logic [1:0] m_axis_tuser
);

    // a stalled result stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // an error result carries zero data and closes its run
    a_bad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 8'h00 && m_axis_tlast)
        else $error("malformed error result");

    // the rest of a multi-byte group is already stored
    a_group: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
        else $error("gap inside a result group");

    // input back-pressure only while results are pending
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no pending result");

endmodule

bind json_string_unescape_utf8 jsu_check u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

// File: test/testbench.sv
// Self-checking stream testbench for the JSON string unescaper with UTF-8 output.
`timescale 1ns / 1ps

module testbench;

    localparam int IDLE_LIMIT  = 1000;
    localparam int TOTAL_REQS  = 210;
    localparam int HOLD_CYCLES = 60;
    localparam logic [7:0] CH_U = 8'h75;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } req_t;

    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       bad;
        logic       fin;
    } out_byte_t;

    logic       clk;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;
    logic       s_axis_tlast = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;
    logic [1:0] m_axis_tuser;

    req_t       pending_reqs[$];
    out_byte_t  expected_bytes[$];
    out_byte_t  group_buf[$];
    logic [7:0] str_buf[$];

    // decoder state of the prediction
    jsu_pkg::mode_t scan = jsu_pkg::MODE_NORMAL;
    int          hex_cnt = 0;
    logic [15:0] cp_acc = '0;
    logic        hex_halt = 1'b0;
    logic        dropping = 1'b0;

    int mismatches = 0;
    int requests_taken = 0;
    int burst_left = 1;
    int gap_left = 0;
    int idle_cycles = 0;
    int rx_cycle = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    json_string_unescape_utf8 uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int hex_nibble(input logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39)
        begin
            return int'(b - 8'h30);
        end
        if (b >= 8'h61 && b <= 8'h66)
        begin
            return int'(b - 8'h61) + 10;
        end
        if (b >= 8'h41 && b <= 8'h46)
        begin
            return int'(b - 8'h41) + 10;
        end
        return -1;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
        if (nib < 4'd10)
        begin
            return 8'h30 + {4'h0, nib};
        end
        return (upper ? 8'h41 : 8'h61) + {4'h0, nib} - 8'd10;
    endfunction

    function automatic bit is_simple_escape(input logic [7:0] b);
        case (b)
            8'h22, 8'h5C, 8'h2F, 8'h62, 8'h66, 8'h6E, 8'h72, 8'h74: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    task automatic add_out(input logic [7:0] data, input logic bad, input logic fin);
        out_byte_t r;
        begin
            r.data     = data;
            r.run_last = 1'b0;
            r.bad      = bad;
            r.fin      = fin;
            group_buf.insert(group_buf.size(), r);
        end
    endtask

    task automatic add_code_point(input logic [15:0] cp, input logic fin);
        if (cp <= 16'h007F)
        begin
            add_out(cp[7:0], 1'b0, fin);
        end
        else if (cp <= 16'h07FF)
        begin
            add_out({3'b110, cp[10:6]}, 1'b0, fin);
            add_out({2'b10, cp[5:0]}, 1'b0, fin);
        end
        else
        begin
            add_out({4'b1110, cp[15:12]}, 1'b0, fin);
            add_out({2'b10, cp[11:6]}, 1'b0, fin);
            add_out({2'b10, cp[5:0]}, 1'b0, fin);
        end
    endtask

    // Advance the predicted decoder by one request and queue the bytes it yields.
    task automatic decode_byte(input logic [7:0] b, input logic last);
        int nib;
        out_byte_t r;
        begin
            if (dropping)
            begin
            end
            else if (scan == jsu_pkg::MODE_ESCAPE)
            begin
                scan = jsu_pkg::MODE_NORMAL;
                case (b)
                    8'h22, 8'h5C, 8'h2F: add_out(b, 1'b0, last);
                    8'h62: add_out(8'h08, 1'b0, last);
                    8'h66: add_out(8'h0C, 1'b0, last);
                    8'h6E: add_out(8'h0A, 1'b0, last);
                    8'h72: add_out(8'h0D, 1'b0, last);
                    8'h74: add_out(8'h09, 1'b0, last);
                    CH_U:
                    begin
                        scan     = jsu_pkg::MODE_HEX;
                        hex_cnt  = 0;
                        cp_acc   = '0;
                        hex_halt = 1'b0;
                        if (last)
                        begin
                            add_code_point(16'h0000, 1'b1);
                        end
                    end
                    default:
                    begin
                        add_out(8'h00, 1'b1, last);
                        dropping = 1'b1;
                    end
                endcase
            end
            else if (scan == jsu_pkg::MODE_HEX)
            begin
                nib = hex_nibble(b);
                if (!hex_halt && nib >= 0)
                begin
                    cp_acc = {cp_acc[11:0], nib[3:0]};
                end
                else
                begin
                    hex_halt = 1'b1;
                end
                hex_cnt = hex_cnt + 1;
                if (hex_cnt >= 4 || last)
                begin
                    add_code_point(cp_acc, last);
                    scan     = jsu_pkg::MODE_NORMAL;
                    hex_cnt  = 0;
                    cp_acc   = '0;
                    hex_halt = 1'b0;
                end
            end
            else if (b == jsu_pkg::BACKSLASH)
            begin
                if (last)
                begin
                    add_out(8'h00, 1'b1, 1'b1);
                end
                else
                begin
                    scan = jsu_pkg::MODE_ESCAPE;
                end
            end
            else
            begin
                add_out(b, 1'b0, last);
            end

            while (group_buf.size() > 0)
            begin
                r = group_buf.pop_front();
                r.run_last = (group_buf.size() == 0);
                expected_bytes.insert(expected_bytes.size(), r);
            end

            if (last)
            begin
                scan     = jsu_pkg::MODE_NORMAL;
                hex_cnt  = 0;
                cp_acc   = '0;
                hex_halt = 1'b0;
                dropping = 1'b0;
            end
        end
    endtask

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    // Stimulus building: collect one string in str_buf, then queue it with tlast on its end.
    task automatic flush_string();
        req_t r;
        begin
            while (str_buf.size() > 0)
            begin
                r.data = str_buf.pop_front();
                r.last = (str_buf.size() == 0);
                pending_reqs.insert(pending_reqs.size(), r);
            end
        end
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            str_buf.insert(str_buf.size(), s[i]);
        end
    endtask

    task automatic put_hex_escape(input logic [15:0] cp, input bit spoil);
        int spoil_at;
        logic [7:0] junk;
        begin
            spoil_at = spoil ? $urandom_range(0, 3) : -1;
            str_buf.insert(str_buf.size(), jsu_pkg::BACKSLASH);
            str_buf.insert(str_buf.size(), CH_U);
            for (int i = 3; i >= 0; i--)
            begin
                if (3 - i == spoil_at)
                begin
                    do
                    begin
                        junk = 8'($urandom_range(0, 255));
                    end
                    while (hex_nibble(junk) >= 0);
                    str_buf.insert(str_buf.size(), junk);
                end
                else
                begin
                    str_buf.insert(str_buf.size(),
                                   hex_char(cp[i*4 +: 4], 1'($urandom_range(0, 1))));
                end
            end
        end
    endtask

    function automatic logic [15:0] random_code_point();
        logic [15:0] edges[6] = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hFFFF};
        case ($urandom_range(0, 7))
            0: return edges[$urandom_range(0, 5)];
            1, 2: return 16'($urandom_range(0, 16'h007F));
            3, 4: return 16'($urandom_range(16'h0080, 16'h07FF));
            default: return 16'($urandom_range(16'h0800, 16'hFFFF));
        endcase
    endfunction

    // Append one random token; returns the count of trailing bytes that get dropped, or -1
    // for an unknown escape with none; any nonzero value means the token must end the string.
    task automatic put_token(output int dropped);
        logic [7:0] simple[8] = '{8'h22, 8'h5C, 8'h2F, 8'h62, 8'h66, 8'h6E, 8'h72, 8'h74};
        logic [7:0] b;
        int pick;
        begin
            dropped = 0;
            pick = $urandom_range(0, 99);
            if (pick < 40 || pick >= 94)
            begin
                do
                begin
                    b = 8'($urandom_range(0, 255));
                end
                while (b == jsu_pkg::BACKSLASH);
                str_buf.insert(str_buf.size(), b);
            end
            else if (pick < 60)
            begin
                str_buf.insert(str_buf.size(), jsu_pkg::BACKSLASH);
                str_buf.insert(str_buf.size(), simple[$urandom_range(0, 7)]);
            end
            else if (pick < 82)
            begin
                put_hex_escape(random_code_point(), 1'b0);
            end
            else if (pick < 88)
            begin
                put_hex_escape(random_code_point(), 1'b1);
            end
            else
            begin
                // unknown escape, then a few bytes that are dropped up to the string end
                do
                begin
                    b = 8'($urandom_range(0, 255));
                end
                while (is_simple_escape(b) || b == CH_U);
                str_buf.insert(str_buf.size(), jsu_pkg::BACKSLASH);
                str_buf.insert(str_buf.size(), b);
                dropped = $urandom_range(0, 3);
                for (int i = 0; i < dropped; i++)
                begin
                    str_buf.insert(str_buf.size(), 8'($urandom_range(0, 255)));
                end
                dropped = (dropped == 0) ? -1 : dropped;
            end
        end
    endtask

    initial
    begin
        int tokens;
        int dropped;
        int keep;
        bit went_bad;

        // extremes and a plain escape
        str_buf.insert(str_buf.size(), 8'h00);
        str_buf.insert(str_buf.size(), 8'hFF);
        put_text("\\n");
        flush_string();
        // three-byte code point, string ends on the fourth hex digit
        put_text("\\uFfFf");
        flush_string();
        // non-hex byte stops the digits, later bytes are still swallowed
        put_text("\\u1g23A");
        flush_string();
        // string ends right on the u
        put_text("\\u");
        flush_string();
        // unknown escape, rest of the string is dropped
        put_text("\\qa\\");
        flush_string();
        // lone backslash as the last byte
        put_text("\\");
        flush_string();

        while (pending_reqs.size() < TOTAL_REQS)
        begin
            tokens   = $urandom_range(1, 10);
            went_bad = 1'b0;
            for (int t = 0; t < tokens && !went_bad; t++)
            begin
                put_token(dropped);
                if (dropped != 0)
                begin
                    went_bad = 1'b1;
                end
            end
            // cut some strings short, possibly inside an escape
            if (!went_bad && $urandom_range(0, 9) == 0)
            begin
                keep = $urandom_range(1, str_buf.size());
                while (str_buf.size() > keep)
                begin
                    void'(str_buf.pop_back());
                end
            end
            flush_string();
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || expected_bytes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("json_string_unescape_utf8 test passed");
        end
        else
        begin
            $display("json_string_unescape_utf8 test failed");
        end
        $finish;
    end

    // Sender: bursts of requests with random gaps; hold a request until it is taken.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                decode_byte(s_axis_tdata, s_axis_tlast);
                void'(pending_reqs.pop_front());
                requests_taken <= requests_taken + 1;
            end

            if (s_axis_tvalid && !s_axis_tready)
            begin
            end
            else if (gap_left > 0)
            begin
                gap_left      <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_reqs.size() == 0)
            begin
                s_axis_tvalid <= 1'b0;
            end
            else
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pending_reqs[0].data;
                s_axis_tlast  <= pending_reqs[0].last;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // Receiver: check each byte against the oldest expectation, stall on a rotating pattern.
    always @(posedge clk)
    begin
        out_byte_t want;
        logic next_ready;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected byte %02h", m_axis_tdata));
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (m_axis_tdata !== want.data)
                    begin
                        report_mismatch($sformatf("byte_out %02h, want %02h",
                                                  m_axis_tdata, want.data));
                    end
                    if (m_axis_tlast !== want.run_last)
                    begin
                        report_mismatch($sformatf("run_last %b, want %b",
                                                  m_axis_tlast, want.run_last));
                    end
                    if (m_axis_tuser[0] !== want.bad)
                    begin
                        report_mismatch($sformatf("bad_escape %b, want %b",
                                                  m_axis_tuser[0], want.bad));
                    end
                    if (m_axis_tuser[1] !== want.fin)
                    begin
                        report_mismatch($sformatf("string_end %b, want %b",
                                                  m_axis_tuser[1], want.fin));
                    end
                end
            end

            rx_cycle <= rx_cycle + 1;
            case ((rx_cycle / 50) % 4)
                0: next_ready = 1'b1;
                1: next_ready = 1'($urandom_range(0, 1));
                2: next_ready = (rx_cycle % 4 == 0);
                default: next_ready = ($urandom_range(0, 99) < 85);
            endcase

            // one long hold-off so the block fills up and stalls its input
            if (!hold_done && requests_taken >= 80)
            begin
                hold_done  <= 1'b1;
                hold_left  <= HOLD_CYCLES;
                next_ready = 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left  <= hold_left - 1;
                next_ready = 1'b0;
            end
            m_axis_tready <= next_ready;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                idle_cycles <= 0;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("json_string_unescape_utf8 test failed");
                $finish;
            end
        end
    end

endmodule
